// ===== rtl/uabd_pkg.sv =====
// Package for the UART auto-baud detector: defaults, register map and rate codes.
`timescale 1ns / 1ps
package uabd_pkg;

  localparam int PHASE_COUNT_DEF = 5;
  localparam int TIMER_BITS_DEF  = 16;

  localparam int NUM_REGS   = 8;
  localparam int REG_BITS   = 16;
  localparam int ADDR_BITS  = 5;
  localparam int DATA_BITS  = 32;
  localparam int CODE_BITS  = 3;
  localparam int GAP_BITS   = 16;
  localparam int STAMP_BITS = 16;

  typedef logic [REG_BITS-1:0] reg_word_t;

  localparam reg_word_t CFG_RESET [NUM_REGS] = '{
    16'd8, 16'd10, 16'd12, 16'd15, 16'd51, 16'd53, 16'd102, 16'd105
  };

  typedef enum logic [2:0] {
    REG_RATE1_LOW  = 3'd0,
    REG_RATE1_HIGH = 3'd1,
    REG_RATE2_LOW  = 3'd2,
    REG_RATE2_HIGH = 3'd3,
    REG_RATE3_LOW  = 3'd4,
    REG_RATE3_HIGH = 3'd5,
    REG_RATE4_LOW  = 3'd6,
    REG_RATE4_HIGH = 3'd7
  } reg_idx_t;

  typedef enum logic [CODE_BITS-1:0] {
    BAUD_INITIAL = 3'd0,
    BAUD_115200  = 3'd1,
    BAUD_76800   = 3'd2,
    BAUD_19200   = 3'd3,
    BAUD_9600    = 3'd4
  } baud_code_t;

  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_TICK   = 1'b1;

endpackage

// ===== rtl/uart_auto_baud_detector.sv =====
// UART auto-baud detector: phase counter, edge gap tracking and rate window match.
// An accepted input item is held in the input register, then the state update
// writes its result into the result register. Throughput: one item per cycle
// unless out_ready stalls it; the state update stage is the only loop.
// Reset (rst_n low, synchronous): windows return to their defaults, phase 0,
// line level high, no edge, no gap, initial rate; both stages are emptied.
`timescale 1ns / 1ps
module uart_auto_baud_detector #(
  parameter int PHASE_COUNT = uabd_pkg::PHASE_COUNT_DEF,
  parameter int TIMER_BITS  = uabd_pkg::TIMER_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_func,
  input  logic                                 in_line_level,
  input  logic [uabd_pkg::STAMP_BITS-1:0]      in_timestamp,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [uabd_pkg::CODE_BITS-1:0]       out_baud_code,
  output logic                                 out_reconfig,
  output logic                                 out_measuring,
  output logic [uabd_pkg::GAP_BITS-1:0]        out_narrowest_gap,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [uabd_pkg::ADDR_BITS-1:0]       paddr,
  input  logic [uabd_pkg::DATA_BITS-1:0]       pwdata,
  output logic [uabd_pkg::DATA_BITS-1:0]       prdata,
  output logic                                 pready
);
  import uabd_pkg::*;

  localparam int PW = (PHASE_COUNT > 1) ? $clog2(PHASE_COUNT) : 1;
  localparam int CW = (TIMER_BITS > REG_BITS) ? TIMER_BITS : REG_BITS;
  localparam logic [PW-1:0] LAST_PHASE = PW'(PHASE_COUNT - 1);

  typedef logic [TIMER_BITS-1:0] tw_t;
  typedef logic [CW-1:0]         cw_t;

  // configuration registers
  reg_word_t cfg_r [NUM_REGS];
  logic      cfg_wr;
  logic [2:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[4:2];
  assign prdata  = DATA_BITS'(cfg_r[cfg_idx]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_wr) begin
      cfg_r[cfg_idx] <= pwdata[REG_BITS-1:0];
    end
  end

  // input register
  logic                  s1_v_r;
  logic                  s1_func_r;
  logic                  s1_level_r;
  logic [STAMP_BITS-1:0] s1_ts_r;
  logic                  s1_go;
  logic                  out_free;

  assign out_free = !out_valid || out_ready;
  assign s1_go    = s1_v_r && out_free;
  assign in_ready = !s1_v_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ready) begin
      s1_v_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_func_r  <= in_func;
      s1_level_r <= in_line_level;
      s1_ts_r    <= in_timestamp;
    end
  end

  // detector state
  logic [PW-1:0]        phase_r, phase_nxt;
  logic                 last_level_r, last_level_nxt;
  tw_t                  edge_time_r, edge_time_nxt;
  tw_t                  min_gap_r, min_gap_nxt;
  logic [CODE_BITS-1:0] rate_code_r, rate_code_nxt;
  logic                 edge_seen_r, edge_seen_nxt;
  logic                 gap_seen_r, gap_seen_nxt;
  logic                 wrapped;

  tw_t                  ts_m;
  tw_t                  gap;
  cw_t                  mg_w;
  logic [3:0]           win_hit;
  logic [CODE_BITS-1:0] pick_code;

  assign ts_m = TIMER_BITS'(s1_ts_r);
  assign gap  = ts_m - edge_time_r;
  assign mg_w = CW'(min_gap_r);

  always_comb begin
    for (int w = 0; w < 4; w++) begin
      win_hit[2'(w)] = (mg_w >= CW'(cfg_r[3'(2*w)])) && (mg_w <= CW'(cfg_r[3'(2*w+1)]));
    end
    if (win_hit[0])      pick_code = BAUD_115200;
    else if (win_hit[1]) pick_code = BAUD_76800;
    else if (win_hit[2]) pick_code = BAUD_19200;
    else if (win_hit[3]) pick_code = BAUD_9600;
    else                 pick_code = rate_code_r;
  end

  always_comb begin
    phase_nxt      = phase_r;
    last_level_nxt = last_level_r;
    edge_time_nxt  = edge_time_r;
    min_gap_nxt    = min_gap_r;
    rate_code_nxt  = rate_code_r;
    edge_seen_nxt  = edge_seen_r;
    gap_seen_nxt   = gap_seen_r;
    wrapped        = 1'b0;
    if (s1_func_r == FUNC_TICK) begin
      if (phase_r == LAST_PHASE) begin
        phase_nxt      = '0;
        rate_code_nxt  = pick_code;
        last_level_nxt = 1'b1;
        edge_time_nxt  = '0;
        edge_seen_nxt  = 1'b0;
        wrapped        = 1'b1;
      end else begin
        phase_nxt = phase_r + PW'(1);
      end
    end else if (phase_r == LAST_PHASE && s1_level_r != last_level_r) begin
      last_level_nxt = s1_level_r;
      if (edge_seen_r && (!gap_seen_r || gap < min_gap_r)) begin
        min_gap_nxt  = gap;
        gap_seen_nxt = 1'b1;
      end
      edge_time_nxt = ts_m;
      edge_seen_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= '0;
      last_level_r <= 1'b1;
      edge_time_r  <= '0;
      min_gap_r    <= '0;
      rate_code_r  <= BAUD_INITIAL;
      edge_seen_r  <= 1'b0;
      gap_seen_r   <= 1'b0;
    end else if (s1_go) begin
      phase_r      <= phase_nxt;
      last_level_r <= last_level_nxt;
      edge_time_r  <= edge_time_nxt;
      min_gap_r    <= min_gap_nxt;
      rate_code_r  <= rate_code_nxt;
      edge_seen_r  <= edge_seen_nxt;
      gap_seen_r   <= gap_seen_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_v_r;
    end
    if (s1_go) begin
      out_baud_code     <= rate_code_nxt;
      out_reconfig      <= wrapped;
      out_measuring     <= (phase_nxt == LAST_PHASE);
      out_narrowest_gap <= GAP_BITS'(min_gap_nxt);
    end
  end

  // checks
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= LAST_PHASE)
    else $error("phase out of range");

  a_gap_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !gap_seen_r |-> (min_gap_r == '0))
    else $error("min gap set without a gap");

  a_wrap_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_func_r == FUNC_TICK && phase_r == LAST_PHASE) |=>
      (phase_r == '0 && !edge_seen_r && last_level_r))
    else $error("wrap did not clear edge tracking");

  a_reconfig_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_reconfig) |-> !out_measuring)
    else $error("reconfig item reports measuring");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    rate_code_r <= BAUD_9600)
    else $error("rate code out of range");

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the UART auto-baud detector: directed and random item traffic.
`timescale 1ns / 1ps
module tb;
  import uabd_pkg::*;

  localparam int PHASES = PHASE_COUNT_DEF;

  typedef struct packed {
    logic [CODE_BITS-1:0] baud;
    logic                 reconfig;
    logic                 measuring;
    logic [GAP_BITS-1:0]  gap;
  } rate_report_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_func = FUNC_SAMPLE;
  logic                  in_line_level = 1'b1;
  logic [STAMP_BITS-1:0] in_timestamp = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b1;
  logic [CODE_BITS-1:0]  out_baud_code;
  logic                  out_reconfig;
  logic                  out_measuring;
  logic [GAP_BITS-1:0]   out_narrowest_gap;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [ADDR_BITS-1:0]  paddr = '0;
  logic [DATA_BITS-1:0]  pwdata = '0;
  logic [DATA_BITS-1:0]  prdata;
  logic                  pready;

  uart_auto_baud_detector #(
    .PHASE_COUNT(PHASES),
    .TIMER_BITS (TIMER_BITS_DEF)
  ) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_line_level    (in_line_level),
    .in_timestamp     (in_timestamp),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_baud_code    (out_baud_code),
    .out_reconfig     (out_reconfig),
    .out_measuring    (out_measuring),
    .out_narrowest_gap(out_narrowest_gap),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // detector shadow state
  int unsigned     ph = 0;
  logic            lvl = 1'b1;
  logic [15:0]     etime = '0;
  logic [15:0]     mgap = '0;
  baud_code_t      rate = BAUD_INITIAL;
  bit              edge_seen = 1'b0;
  bit              gap_seen = 1'b0;
  reg_word_t       win [NUM_REGS] = CFG_RESET;

  rate_report_t    pending_reports [$];

  bit              quiet_in = 1'b0;
  bit              quiet_out = 1'b0;
  int              out_hold = 0;
  int              mismatches = 0;
  int              items_sent = 0;
  int              live_items = 0;
  int              reports_checked = 0;
  int              ticks_sent = 0;
  int              window_closes = 0;
  int              reg_writes = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("timeout: %0d reports still pending", pending_reports.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int draw_wait(bit quiet);
    return quiet ? 0 : $urandom_range(0, 16);
  endfunction

  task automatic flag_fault(string why, rate_report_t want, rate_report_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: want baud=%0d reconfig=%0b measuring=%0b gap=%0d, %s",
               $realtime, why, want.baud, want.reconfig, want.measuring, want.gap,
               $sformatf("got baud=%0d reconfig=%0b measuring=%0b gap=%0d",
                         got.baud, got.reconfig, got.measuring, got.gap));
  endtask

  task automatic detector_step(input logic f, input logic l, input logic [15:0] ts,
                               output rate_report_t r);
    logic [15:0] gap;
    logic        wrapped;
    int          w;
    int          pick;
    wrapped = 1'b0;
    pick = 0;
    if (f == FUNC_TICK) begin
      ticks_sent++;
      ph = (ph + 1) % PHASES;
      if (ph == 0) begin
        for (w = 3; w >= 0; w--)
          if (mgap >= win[3'(2 * w)] && mgap <= win[3'(2 * w + 1)]) pick = w + 1;
        if (pick != 0) rate = baud_code_t'(pick);
        lvl = 1'b1;
        etime = '0;
        edge_seen = 1'b0;
        wrapped = 1'b1;
        window_closes++;
      end
    end else if (ph == PHASES - 1 && l != lvl) begin
      lvl = l;
      if (edge_seen) begin
        gap = ts - etime;
        if (!gap_seen || gap < mgap) begin
          mgap = gap;
          gap_seen = 1'b1;
        end
      end
      etime = ts;
      edge_seen = 1'b1;
    end
    r.baud = rate;
    r.reconfig = wrapped;
    r.measuring = (ph == PHASES - 1);
    r.gap = mgap;
  endtask

  task automatic send_item(input logic f, input logic l, input logic [15:0] ts);
    int           idle;
    rate_report_t r;
    idle = draw_wait(quiet_in);
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_line_level <= l;
    in_timestamp <= ts;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (f == FUNC_TICK || ph == PHASES - 1) live_items++;
    items_sent++;
    detector_step(f, l, ts, r);
    pending_reports.push_back(r);
  endtask

  task automatic cfg_write(input reg_idx_t idx, input reg_word_t val);
    logic [DATA_BITS-1:0] word;
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    word = $urandom;
    word[REG_BITS-1:0] = val;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    win[idx] = val;
    reg_writes++;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== DATA_BITS'(val)) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t readback of register %s: want %0d, got %0d",
                 $realtime, idx.name(), val, prdata);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic goto_measuring();
    while (ph != PHASES - 1)
      send_item(FUNC_TICK, 1'($urandom_range(0, 1)), 16'($urandom));
  endtask

  // result side: check, then hold ready low while a drawn wait runs down
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        flag_fault("report with nothing pending", '0,
                   {out_baud_code, out_reconfig, out_measuring, out_narrowest_gap});
      end else if ({out_baud_code, out_reconfig, out_measuring, out_narrowest_gap}
                   !== pending_reports[0]) begin
        flag_fault("report mismatch", pending_reports[0],
                   {out_baud_code, out_reconfig, out_measuring, out_narrowest_gap});
      end
      if (pending_reports.size() != 0) void'(pending_reports.pop_front());
      reports_checked++;
      out_hold = draw_wait(quiet_out);
      out_ready <= (out_hold == 0);
    end else if (out_hold > 0) begin
      out_hold--;
      if (out_hold == 0) out_ready <= 1'b1;
    end
  end

  task automatic test_edge_tracking();
    send_item(FUNC_SAMPLE, 1'b0, 16'h0000);  // outside measuring phase
    goto_measuring();
    send_item(FUNC_SAMPLE, 1'b1, 16'hFFFF);  // level unchanged, no edge
    send_item(FUNC_SAMPLE, 1'b0, 16'hFFF0);  // first edge only records time
    send_item(FUNC_SAMPLE, 1'b1, 16'h0056);  // gap of 102 across timer wrap
    send_item(FUNC_TICK, 1'b0, 16'h0000);    // close -> 9600
    goto_measuring();
    send_item(FUNC_SAMPLE, 1'b0, 16'h1234);
    send_item(FUNC_SAMPLE, 1'b1, 16'h1248);  // gap 20 fits no default window
    send_item(FUNC_TICK, 1'b1, 16'hFFFF);
  endtask

  task automatic test_window_registers();
    cfg_write(REG_RATE1_LOW, 16'hFFFF);      // low above high
    cfg_write(REG_RATE1_HIGH, 16'h0000);
    cfg_write(REG_RATE2_LOW, 16'h0000);      // full range
    cfg_write(REG_RATE2_HIGH, 16'hFFFF);
    repeat (PHASES) send_item(FUNC_TICK, 1'($urandom_range(0, 1)), 16'($urandom));
    cfg_write(REG_RATE2_LOW, 16'd21);
    cfg_write(REG_RATE2_HIGH, 16'd19);
    cfg_write(REG_RATE3_LOW, 16'd20);        // exact hit, overlaps window 4
    cfg_write(REG_RATE3_HIGH, 16'd20);
    cfg_write(REG_RATE4_LOW, 16'h0000);
    cfg_write(REG_RATE4_HIGH, 16'hFFFF);
    repeat (PHASES) send_item(FUNC_TICK, 1'($urandom_range(0, 1)), 16'($urandom));
  endtask

  task automatic reprogram_windows();
    int w;
    int lo;
    int hi;
    int m;
    m = int'(mgap);
    for (w = 0; w < 4; w++) begin
      case ($urandom_range(0, 4))
        0: begin
          lo = $urandom_range(0, 65535);
          hi = $urandom_range(0, 65535);
        end
        1: begin
          lo = m - $urandom_range(0, 3);
          hi = m + $urandom_range(0, 3);
        end
        2: begin
          lo = 0;
          hi = 65535;
        end
        3: begin
          lo = $urandom_range(1, 65535);
          hi = $urandom_range(0, lo - 1);
        end
        default: begin
          lo = m + 1;
          hi = m + $urandom_range(1, 50);
        end
      endcase
      if (lo < 0) lo = 0;
      if (lo > 65535) lo = 65535;
      if (hi > 65535) hi = 65535;
      cfg_write(reg_idx_t'(2 * w), reg_word_t'(lo));
      cfg_write(reg_idx_t'(2 * w + 1), reg_word_t'(hi));
    end
  endtask

  task automatic measure_burst();
    int          n;
    int          k;
    int          mode;
    logic [15:0] t;
    logic [15:0] step;
    logic        lv;
    goto_measuring();
    t = 16'($urandom);
    n = $urandom_range(1, 12);
    for (k = 0; k < n; k++) begin
      mode = $urandom_range(0, 15);
      if (mode == 0) step = (mgap > 3) ? mgap - 16'($urandom_range(1, 2)) : mgap;
      else if (mode <= 5) step = mgap + 16'($urandom_range(0, 40));
      else if (mode <= 9) step = 16'($urandom);
      else step = 16'($urandom_range(1, 400));
      t = t + step;
      lv = ($urandom_range(0, 5) == 0) ? lvl : ~lvl;
      send_item(FUNC_SAMPLE, lv, t);
      if ($urandom_range(0, 19) == 0)
        send_item(FUNC_TICK, 1'($urandom_range(0, 1)), 16'($urandom));
    end
    if (ph == PHASES - 1) send_item(FUNC_TICK, 1'($urandom_range(0, 1)), 16'($urandom));
  endtask

  task automatic test_random_traffic();
    int n;
    while (live_items < 800) begin
      quiet_in = ($urandom_range(0, 3) == 0);
      quiet_out = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) == 0) reprogram_windows();
      if ($urandom_range(0, 3) == 0) begin
        n = $urandom_range(3, 10);
        repeat (n) send_item(($urandom_range(0, 2) == 0) ? FUNC_TICK : FUNC_SAMPLE,
                             1'($urandom_range(0, 1)), 16'($urandom));
      end else begin
        measure_burst();
      end
    end
    quiet_in = 1'b0;
    quiet_out = 1'b0;
  endtask

  task automatic test_zero_gap();
    logic [15:0] t;
    cfg_write(REG_RATE1_LOW, 16'h0000);
    cfg_write(REG_RATE1_HIGH, 16'h0000);
    goto_measuring();
    t = 16'($urandom);
    send_item(FUNC_SAMPLE, ~lvl, t);
    send_item(FUNC_SAMPLE, ~lvl, t);         // same stamp: zero-width gap
    send_item(FUNC_TICK, 1'($urandom_range(0, 1)), 16'($urandom));
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_edge_tracking();
    test_window_registers();
    test_random_traffic();
    test_zero_gap();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("run covered %0d items (%0d ticks, %0d window closes), %0d reports checked",
             items_sent, ticks_sent, window_closes, reports_checked);
    $display("%0d register writes with readback, %0d mismatches", reg_writes, mismatches);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
